>>> hw/rtl/color_sharpen_3x3_stream_macros.svh
// Assertion macros used by the colour sharpener back end.
`ifndef COLOR_SHARPEN_3X3_STREAM_MACROS_SVH
`define COLOR_SHARPEN_3X3_STREAM_MACROS_SVH
// same-cycle implication
`define CSS_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define CSS_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> hw/rtl/css_pkg.sv
// Shared constants and types of the colour sharpener.
package css_pkg;
	localparam int DEF_MAX_COLS    = 2048;
	localparam int DEF_MAX_ROWS    = 2048;
	localparam int DEF_SAMPLE_BITS = 8;

	localparam logic [11:0] RST_IMAGE_COLS = 12'd640;
	localparam logic [11:0] RST_IMAGE_ROWS = 12'd480;
	localparam logic [6:0]  RST_PERCENT    = 7'd75;

	localparam logic [1:0] REG_IMAGE_COLS = 2'd0;
	localparam logic [1:0] REG_IMAGE_ROWS = 2'd1;
	localparam logic [1:0] REG_PERCENT    = 2'd2;

	localparam int MIN_SIZE    = 3;
	localparam int PERCENT_MAX = 99;
	localparam int SCALE       = 900;
	localparam int DEN_BITS    = 10;

	typedef struct packed {
		logic border;
		logic last;
	} css_flags_t;
endpackage

>>> hw/rtl/css_queue.sv
// Two-entry queue between the window front end and the arithmetic back end.
module css_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             rvalid,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       count_q;

	assign full   = (count_q == 2'd2);
	assign rvalid = (count_q != 2'd0);
	assign rdata  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wdata;
	end
endmodule

>>> hw/rtl/css_front.sv
// Front end: raster counters, line store, 3x3 window and result classification.
module css_front #(
	parameter int MAX_COLS    = 2048,
	parameter int MAX_ROWS    = 2048,
	parameter int SAMPLE_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [$clog2(MAX_COLS+1)-1:0]  cols,
	input  logic [$clog2(MAX_ROWS+1)-1:0]  rows,
	input  logic                           restart,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [SAMPLE_BITS-1:0]         red,
	input  logic [SAMPLE_BITS-1:0]         green,
	input  logic [SAMPLE_BITS-1:0]         blue,
	input  logic                           q_full,
	output logic                           push,
	output logic [3*SAMPLE_BITS-1:0]       centre,
	output logic [3*(SAMPLE_BITS+4)-1:0]   sum,
	output css_pkg::css_flags_t            flags
);
	import css_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int PW   = 3 * SB;
	localparam int SUMW = SB + 4;
	localparam int CIW  = $clog2(MAX_COLS);
	localparam int RIW  = $clog2(MAX_ROWS + 2);
	localparam int ORW  = $clog2(MAX_ROWS);

	logic [2*PW-1:0] line_mem [MAX_COLS];
	logic [2*PW-1:0] rd_q;
	logic [PW-1:0]   win_q [3][2];
	logic [CIW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
	logic [RIW-1:0]  in_row_q, in_row_d;
	logic [ORW-1:0]  out_row_q, out_row_d;
	logic [PW-1:0]   s, older, newer;
	logic            hit, go, emit, wrap, border, last;

	assign in_stall = q_full;
	assign hit   = cmd ? (32'(in_row_q) >= 32'(rows)) : (32'(in_row_q) < 32'(rows));
	assign go    = in_valid && !q_full && hit;
	assign s     = cmd ? '0 : {blue, green, red};
	assign older = rd_q[2*PW-1:PW];
	assign newer = rd_q[PW-1:0];
	assign emit  = (32'(in_row_q) > 32'd1) || ((32'(in_row_q) == 32'd1) && (in_col_q != '0));
	assign wrap  = (32'(in_col_q) + 32'd1) >= 32'(cols);
	assign border = (out_row_q == '0) || (32'(out_row_q) >= 32'(rows) - 32'd1) ||
	                (out_col_q == '0) || (32'(out_col_q) >= 32'(cols) - 32'd1);
	assign last  = (32'(out_row_q) == 32'(rows) - 32'd1) &&
	               (32'(out_col_q) == 32'(cols) - 32'd1);

	assign push         = go && emit;
	assign centre       = win_q[1][1];
	assign flags.border = border;
	assign flags.last   = last;

	always_comb begin
		logic [SUMW-1:0] acc;
		for (int ch = 0; ch < 3; ch++) begin
			acc = '0;
			for (int r = 0; r < 3; r++) begin
				acc = acc + SUMW'(win_q[r][0][ch*SB +: SB]) + SUMW'(win_q[r][1][ch*SB +: SB]);
			end
			acc = acc + SUMW'(older[ch*SB +: SB]) + SUMW'(newer[ch*SB +: SB]) +
			      SUMW'(s[ch*SB +: SB]);
			sum[ch*SUMW +: SUMW] = acc;
		end
	end

	always_comb begin
		in_col_d  = in_col_q;
		in_row_d  = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (restart) begin
			in_col_d  = '0;
			in_row_d  = '0;
			out_col_d = '0;
			out_row_d = '0;
		end else if (go) begin
			if (wrap) begin
				in_col_d = '0;
				in_row_d = in_row_q + 1'b1;
			end else begin
				in_col_d = in_col_q + 1'b1;
			end
			if (emit) begin
				if (32'(out_col_q) + 32'd1 >= 32'(cols)) begin
					out_col_d = '0;
					out_row_d = out_row_q + 1'b1;
				end else begin
					out_col_d = out_col_q + 1'b1;
				end
				if (last) begin
					in_col_d  = '0;
					in_row_d  = '0;
					out_col_d = '0;
					out_row_d = '0;
				end
			end
		end
	end

	// window: column 0 oldest; column 2 is the incoming column, not stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= '0;
				win_q[r][1] <= '0;
			end
		end else begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
			if (go) begin
				for (int r = 0; r < 3; r++) win_q[r][0] <= win_q[r][1];
				win_q[0][1] <= older;
				win_q[1][1] <= newer;
				win_q[2][1] <= s;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) line_mem[in_col_q] <= {newer, s};
		rd_q <= line_mem[in_col_d];
	end
endmodule

>>> hw/rtl/css_back.sv
// Back end: numerator, rounding divider, saturation and output register.
`include "color_sharpen_3x3_stream_macros.svh"
module css_back #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [6:0]                   p,
	input  logic [css_pkg::DEN_BITS-1:0] den,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  logic [3*SAMPLE_BITS-1:0]     centre,
	input  logic [3*(SAMPLE_BITS+4)-1:0] sum,
	input  css_pkg::css_flags_t          flags,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [15:0]           red_out,
	output logic signed [15:0]           green_out,
	output logic signed [15:0]           blue_out,
	output logic                         frame_last
);
	import css_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int SUMW = SB + 4;
	localparam int NW   = SB + 12;
	localparam int CW   = $clog2(NW);
	localparam int RMW  = DEN_BITS + 1;

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_PREP, ST_DIV, ST_DONE} state_t;

	state_t            state_q;
	logic [SB-1:0]     c_q   [3];
	logic [SUMW-1:0]   sum_q [3];
	logic [NW-1:0]     num_q [3];
	logic [NW-1:0]     n_q   [3];
	logic [RMW-1:0]    rem_q [3];
	logic              neg_q [3];
	css_flags_t        flags_q;
	logic [CW-1:0]     cnt_q;
	logic              out_valid_q;
	logic [RMW:0]      dsr;
	logic              load;

	function automatic logic signed [15:0] sat16(logic [31:0] mag, logic neg);
		logic signed [15:0] r;
		if (neg) r = (mag > 32'd32768) ? -16'sd32768 : 16'(-mag);
		else     r = (mag > 32'd32767) ? 16'sd32767 : 16'(mag);
		return r;
	endfunction

	assign dsr       = {1'b0, den, 1'b0};
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign load      = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		logic [RMW:0]  rs;
		logic [NW-1:0] mag;
		logic signed [15:0] res [3];
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && !load) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						for (int ch = 0; ch < 3; ch++) begin
							c_q[ch]   <= centre[ch*SB +: SB];
							sum_q[ch] <= sum[ch*SUMW +: SUMW];
						end
						flags_q <= flags;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					for (int ch = 0; ch < 3; ch++)
						num_q[ch] <= NW'(c_q[ch]) * NW'(SCALE) - NW'(p) * NW'(sum_q[ch]);
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					for (int ch = 0; ch < 3; ch++) begin
						mag = num_q[ch][NW-1] ? -num_q[ch] : num_q[ch];
						neg_q[ch] <= num_q[ch][NW-1];
						n_q[ch]   <= {mag[NW-2:0], 1'b0} + NW'(den);
						rem_q[ch] <= '0;
					end
					cnt_q   <= CW'(NW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					for (int ch = 0; ch < 3; ch++) begin
						rs = {rem_q[ch], n_q[ch][NW-1]};
						if (rs >= dsr) begin
							rem_q[ch] <= RMW'(rs - dsr);
							n_q[ch]   <= {n_q[ch][NW-2:0], 1'b1};
						end else begin
							rem_q[ch] <= RMW'(rs);
							n_q[ch]   <= {n_q[ch][NW-2:0], 1'b0};
						end
					end
					if (cnt_q == '0) state_q <= ST_DONE;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_DONE: begin
					if (load) begin
						for (int ch = 0; ch < 3; ch++) begin
							if (flags_q.border) res[ch] = sat16(32'(c_q[ch]), 1'b0);
							else res[ch] = sat16(32'(n_q[ch]), neg_q[ch]);
						end
						red_out     <= res[0];
						green_out   <= res[1];
						blue_out    <= res[2];
						frame_last  <= flags_q.last;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CSS_ASSERT_IMP(a_pop_nonempty, clk, arst_n, q_pop, q_valid, "pop from empty queue")
	`CSS_ASSERT_IMP(a_load_free, clk, arst_n, load, (!out_valid_q || !out_stall), "output overwritten")
	`CSS_ASSERT_NXT(a_div_end, clk, arst_n, (state_q == ST_DIV && cnt_q == '0), (state_q == ST_DONE), "divider overran")
endmodule

>>> hw/rtl/color_sharpen_3x3_stream.sv
// Colour 3x3 sharpener top level: register port, front end, queue, back end.
// Usage:
//  Input channel (in_valid/in_stall): cmd=0 transfers one RGB pixel in raster
//  order; after a frame's last pixel, cmd=1 drain transfers flush the pending
//  results (one row plus one pixel of them). Output channel (out_valid/
//  out_stall) carries the sharpened pixel and frame_last.
//  A transfer that yields a result is classified and queued; the back end
//  then forms the numerator, runs the rounding divider one quotient bit per
//  cycle and saturates into the output register, taking a new result only
//  when it is through with the last one.
//  The two-entry queue lets pixels be taken while the divider is busy; input
//  stalls when it is full.
//  While the receiver stalls, the result holds in the output register and the
//  back end waits in its final state; the queue then fills and stalls input.
//  Reset clears counters, window, queue and registers to their defaults;
//  line store contents are undefined until written. Writing image_cols or
//  image_rows restarts the frame.
module color_sharpen_3x3_stream #(
	parameter int MAX_COLS    = css_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS    = css_pkg::DEF_MAX_ROWS,
	parameter int SAMPLE_BITS = css_pkg::DEF_SAMPLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] red_out,
	output logic signed [15:0] green_out,
	output logic signed [15:0] blue_out,
	output logic               frame_last
);
	import css_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int SUMW = SB + 4;
	localparam int CNW  = $clog2(MAX_COLS + 1);
	localparam int RNW  = $clog2(MAX_ROWS + 1);
	localparam int QW   = 2 + 3 * SUMW + 3 * SB;

	logic [11:0]          cols_q, rows_q;
	logic [6:0]           pct_q, pc;
	logic [CNW-1:0]       cols;
	logic [RNW-1:0]       rows;
	logic [DEN_BITS-1:0]  den;
	logic                 wr, restart;
	logic [15:0]          r_ext, g_ext, b_ext;
	logic                 push, q_full, q_valid, q_pop;
	logic [3*SB-1:0]      centre, q_centre;
	logic [3*SUMW-1:0]    sum, q_sum;
	css_flags_t           flags, q_flags;
	logic [QW-1:0]        q_rdata;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign restart = wr && (paddr[3:2] == REG_IMAGE_COLS || paddr[3:2] == REG_IMAGE_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= RST_IMAGE_COLS;
			rows_q <= RST_IMAGE_ROWS;
			pct_q  <= RST_PERCENT;
		end else if (wr) begin
			case (paddr[3:2])
				REG_IMAGE_COLS: cols_q <= pwdata[11:0];
				REG_IMAGE_ROWS: rows_q <= pwdata[11:0];
				REG_PERCENT:    pct_q  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_IMAGE_COLS: prdata = {20'd0, cols_q};
			REG_IMAGE_ROWS: prdata = {20'd0, rows_q};
			REG_PERCENT:    prdata = {25'd0, pct_q};
			default:        prdata = '0;
		endcase
	end

	assign cols = (32'(cols_q) < MIN_SIZE) ? CNW'(MIN_SIZE) :
	              (32'(cols_q) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(cols_q);
	assign rows = (32'(rows_q) < MIN_SIZE) ? RNW'(MIN_SIZE) :
	              (32'(rows_q) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(rows_q);
	assign pc   = (32'(pct_q) > PERCENT_MAX) ? 7'(PERCENT_MAX) : pct_q;
	assign den  = DEN_BITS'(SCALE - 9 * 32'(pc));

	assign r_ext = {8'd0, red_in};
	assign g_ext = {8'd0, green_in};
	assign b_ext = {8'd0, blue_in};

	css_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .SAMPLE_BITS(SB)) u_front (
		.clk, .arst_n, .cols, .rows, .restart, .in_valid, .in_stall, .cmd,
		.red(r_ext[SB-1:0]), .green(g_ext[SB-1:0]), .blue(b_ext[SB-1:0]),
		.q_full, .push, .centre, .sum, .flags
	);

	css_queue #(.WIDTH(QW)) u_queue (
		.clk, .arst_n, .push, .wdata({flags, sum, centre}), .full(q_full),
		.pop(q_pop), .rvalid(q_valid), .rdata(q_rdata)
	);

	assign q_centre = q_rdata[3*SB-1:0];
	assign q_sum    = q_rdata[3*SB +: 3*SUMW];
	assign q_flags  = q_rdata[QW-1 -: 2];

	css_back #(.SAMPLE_BITS(SB)) u_back (
		.clk, .arst_n, .p(pc), .den, .q_valid, .q_pop, .centre(q_centre), .sum(q_sum),
		.flags(q_flags), .out_valid, .out_stall, .red_out, .green_out, .blue_out, .frame_last
	);
endmodule
